// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int CoefWidth = 16;
   localparam int ValWidth  = 32;
   localparam int KindWidth = 3;
   localparam int DiscWidth = 35;   // |b*b - 4ac| fits below 2^34
   localparam int RadWidth  = 64;   // |d| << 30
   localparam int RootWidth = 32;   // isqrt result
   localparam int NumWidth  = 34;   // dividend magnitude
   localparam int DenWidth  = 16;   // divisor magnitude
   localparam int QuoWidth  = 34;   // quotient magnitude

   localparam logic [KindWidth-1:0] KIND_REAL     = 3'd0;
   localparam logic [KindWidth-1:0] KIND_COMPLEX  = 3'd1;
   localparam logic [KindWidth-1:0] KIND_LINEAR   = 3'd2;
   localparam logic [KindWidth-1:0] KIND_INFINITE = 3'd3;
   localparam logic [KindWidth-1:0] KIND_NONE     = 3'd4;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 neg_disc;
      logic                 b_neg;
      logic [CoefWidth-1:0] b_mag;
      logic                 a_neg;
      logic [DenWidth-1:0]  den_mag;
      logic                 lin_neg;
      logic [NumWidth-1:0]  lin_mag;
   } side_type;

endpackage : qrs_pkg
`default_nettype wire

// File: rtl/qrs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module qrs_isqrt
   import qrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic [RadWidth-1:0]  in_rad,
   input  wire side_type             in_side,
   output logic                      out_valid,
   output logic [RootWidth-1:0]      out_root,
   output side_type                  out_side
);

   localparam int Steps = RootWidth;

   logic                 valid_ff [Steps+1];
   logic [RadWidth-1:0]  rem_ff   [Steps+1];
   logic [RootWidth-1:0] root_ff  [Steps+1];
   side_type             side_ff  [Steps+1];

   always_comb begin
      valid_ff[0] = in_valid;
      rem_ff[0]   = in_rad;
      root_ff[0]  = '0;
      side_ff[0]  = in_side;
   end

   for (genvar g = 0; g < Steps; g++) begin : g_step
      localparam int Sh = 2 * (Steps - 1 - g);
      logic [RadWidth-1:0]  trial_in;
      logic [RadWidth-1:0]  rem_in;
      logic [RootWidth-1:0] root_in;
      logic                 valid_ff_r;
      logic [RadWidth-1:0]  rem_ff_r;
      logic [RootWidth-1:0] root_ff_r;
      side_type             side_ff_r;

      always_comb begin
         trial_in = (RadWidth'({root_ff[g], 2'b01})) << Sh;
         if (rem_ff[g] >= trial_in) begin
            rem_in  = rem_ff[g] - trial_in;
            root_in = {root_ff[g][RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = rem_ff[g];
            root_in = {root_ff[g][RootWidth-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff_r <= 1'b0;
         end else if (advance) begin
            valid_ff_r <= valid_ff[g];
         end
         if (advance) begin
            rem_ff_r  <= rem_in;
            root_ff_r <= root_in;
            side_ff_r <= side_ff[g];
         end
      end

      always_comb begin
         valid_ff[g+1] = valid_ff_r;
         rem_ff[g+1]   = rem_ff_r;
         root_ff[g+1]  = root_ff_r;
         side_ff[g+1]  = side_ff_r;
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_root  = root_ff[Steps];
   assign out_side  = side_ff[Steps];

endmodule : qrs_isqrt
`default_nettype wire

// File: rtl/qrs_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_divider
// Pipelined restoring divider of magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_divider
   import qrs_pkg::*;
#(
   parameter int TagWidth = 1
)
(
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic [NumWidth-1:0] in_num,
   input  wire logic [DenWidth-1:0] in_den,
   input  wire logic [TagWidth-1:0] in_tag,
   output logic [QuoWidth-1:0]      out_quo,
   output logic [TagWidth-1:0]      out_tag
);

   localparam int Steps   = NumWidth;
   localparam int RemBits = DenWidth + 1;

   logic [NumWidth-1:0] num_ff [Steps+1];
   logic [RemBits-1:0]  rem_ff [Steps+1];
   logic [DenWidth-1:0] den_ff [Steps+1];
   logic [TagWidth-1:0] tag_ff [Steps+1];

   always_comb begin
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
      tag_ff[0] = in_tag;
   end

   for (genvar g = 0; g < Steps; g++) begin : g_step
      logic [RemBits-1:0]  shift_in;
      logic [RemBits-1:0]  rem_in;
      logic [NumWidth-1:0] num_in;
      logic [NumWidth-1:0] num_r;
      logic [RemBits-1:0]  rem_r;
      logic [DenWidth-1:0] den_r;
      logic [TagWidth-1:0] tag_r;

      always_comb begin
         shift_in = {rem_ff[g][RemBits-2:0], num_ff[g][NumWidth-1]};
         if (shift_in >= RemBits'(den_ff[g])) begin
            rem_in = shift_in - RemBits'(den_ff[g]);
            num_in = {num_ff[g][NumWidth-2:0], 1'b1};
         end else begin
            rem_in = shift_in;
            num_in = {num_ff[g][NumWidth-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_r <= num_in;
            rem_r <= rem_in;
            den_r <= den_ff[g];
            tag_r <= tag_ff[g];
         end
      end

      always_comb begin
         num_ff[g+1] = num_r;
         rem_ff[g+1] = rem_r;
         den_ff[g+1] = den_r;
         tag_ff[g+1] = tag_r;
      end
   end

   assign out_quo = QuoWidth'(num_ff[Steps]);
   assign out_tag = tag_ff[Steps];

endmodule : qrs_divider
`default_nettype wire

// File: rtl/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Solves a*x^2+b*x+c=0 on Q8.8 coefficients, giving Q16.16 roots.
// ----------------------------------------------------------------------------
// One coefficient triple is taken per cycle while req_stall is low. A product
// stage and a discriminant stage feed a 32-stage square root, then a dividend
// stage feeds a 34-stage divider pair and the output register. The whole pipeline advances when the
// output register is empty or being taken, so rsp_stall backs up to req_stall.
module quadratic_root_solver_unit
   import qrs_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [CoefWidth-1:0] req_coef_quad,
   input  wire logic signed [CoefWidth-1:0] req_coef_lin,
   input  wire logic signed [CoefWidth-1:0] req_coef_const,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [KindWidth-1:0]             rsp_solution_kind,
   output logic signed [ValWidth-1:0]       rsp_first_value,
   output logic signed [ValWidth-1:0]       rsp_second_value
);

   localparam int TagWidth = 1 + KindWidth + 2;

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: products
   logic                 s1_valid_ff;
   logic signed [31:0]   s1_bb_ff;
   logic signed [33:0]   s1_4ac_ff;
   logic signed [15:0]   s1_a_ff, s1_b_ff, s1_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_bb_ff  <= 32'(req_coef_lin) * 32'(req_coef_lin);
         s1_4ac_ff <= 34'(32'(req_coef_quad) * 32'(req_coef_const)) <<< 2;
         s1_a_ff   <= req_coef_quad;
         s1_b_ff   <= req_coef_lin;
         s1_c_ff   <= req_coef_const;
      end
   end

   // stage 2: discriminant, kind and linear dividend
   logic                        s2_valid_ff;
   logic [RadWidth-1:0]         s2_rad_ff;
   side_type                    s2_side_ff;
   logic signed [DiscWidth-1:0] disc_in;
   logic [DiscWidth-1:0]        dmag_in;
   side_type                    side_in;

   always_comb begin
      disc_in = DiscWidth'(s1_bb_ff) - DiscWidth'(s1_4ac_ff);
      dmag_in = disc_in[DiscWidth-1] ? DiscWidth'(-disc_in) : DiscWidth'(disc_in);
      side_in.neg_disc = disc_in[DiscWidth-1];
      side_in.b_neg    = s1_b_ff[15];
      side_in.b_mag    = s1_b_ff[15] ? 16'(-s1_b_ff) : 16'(s1_b_ff);
      side_in.lin_neg  = !s1_c_ff[15] && (s1_c_ff != 16'sd0);
      side_in.lin_mag  = NumWidth'(s1_c_ff[15] ? 17'(-17'(s1_c_ff)) : 17'(s1_c_ff)) << 16;
      if (s1_a_ff != 16'sd0) begin
         side_in.kind    = disc_in[DiscWidth-1] ? KIND_COMPLEX : KIND_REAL;
         side_in.a_neg   = s1_a_ff[15];
         side_in.den_mag = s1_a_ff[15] ? 16'(-s1_a_ff) : 16'(s1_a_ff);
      end else begin
         side_in.a_neg   = s1_b_ff[15];
         side_in.den_mag = side_in.b_mag;
         if (s1_b_ff != 16'sd0) begin
            side_in.kind = KIND_LINEAR;
         end else if (s1_c_ff == 16'sd0) begin
            side_in.kind = KIND_INFINITE;
            side_in.den_mag = 16'd1;
         end else begin
            side_in.kind = KIND_NONE;
            side_in.den_mag = 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_rad_ff  <= RadWidth'(dmag_in) << 30;
         s2_side_ff <= side_in;
      end
   end

   logic                 sq_valid;
   logic [RootWidth-1:0] sq_root;
   side_type             sq_side;

   qrs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_rad    (s2_rad_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 3: signed dividends as magnitudes with sign
   logic                 s3_valid_ff;
   logic [NumWidth-1:0]  s3_n1_ff, s3_n2_ff;
   logic                 s3_n1neg_ff, s3_n2neg_ff;
   logic [DenWidth-1:0]  s3_den_ff;
   logic [KindWidth-1:0] s3_kind_ff;
   logic                 s3_aneg_ff;
   logic signed [NumWidth+1:0] nb_in, v1_in, v2_in;

   always_comb begin
      nb_in = (NumWidth+2)'(sq_side.b_mag) << 15;
      if (!sq_side.b_neg) nb_in = -nb_in;
      v1_in = nb_in;
      v2_in = (NumWidth+2)'(sq_root);
      if (sq_side.kind == KIND_REAL) begin
         v1_in = nb_in + (NumWidth+2)'(sq_root);
         v2_in = nb_in - (NumWidth+2)'(sq_root);
      end else if (sq_side.kind == KIND_LINEAR) begin
         v1_in = sq_side.lin_neg ? -(NumWidth+2)'(sq_side.lin_mag)
                                 : (NumWidth+2)'(sq_side.lin_mag);
         v2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= sq_valid;
      end
      if (advance) begin
         s3_n1neg_ff <= v1_in[NumWidth+1];
         s3_n2neg_ff <= v2_in[NumWidth+1];
         s3_n1_ff    <= v1_in[NumWidth+1] ? NumWidth'(-v1_in) : NumWidth'(v1_in);
         s3_n2_ff    <= v2_in[NumWidth+1] ? NumWidth'(-v2_in) : NumWidth'(v2_in);
         s3_den_ff   <= sq_side.den_mag;
         s3_kind_ff  <= sq_side.kind;
         s3_aneg_ff  <= sq_side.a_neg;
      end
   end

   logic [QuoWidth-1:0] q1, q2;
   logic [TagWidth-1:0] tag1;
   logic                tag2;
   logic                dv_valid;
   logic [KindWidth-1:0] dv_kind;
   logic                dv_neg1, dv_neg2;

   qrs_divider #(.TagWidth(TagWidth)) u_div1 (
      .clock   (clock),
      .advance (advance),
      .in_num  (s3_n1_ff),
      .in_den  (s3_den_ff),
      .in_tag  ({s3_valid_ff, s3_kind_ff, s3_n1neg_ff ^ s3_aneg_ff,
                 s3_n2neg_ff ^ s3_aneg_ff}),
      .out_quo (q1),
      .out_tag (tag1)
   );

   qrs_divider #(.TagWidth(1)) u_div2 (
      .clock   (clock),
      .advance (advance),
      .in_num  (s3_n2_ff),
      .in_den  (s3_den_ff),
      .in_tag  (s3_valid_ff),
      .out_quo (q2),
      .out_tag (tag2)
   );

   // divider tag valid is not reset, so gate with a reset-cleared shadow chain
   localparam int DivLat = NumWidth;
   logic [DivLat-1:0] dv_chain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_chain_ff <= '0;
      end else if (advance) begin
         dv_chain_ff <= {dv_chain_ff[DivLat-2:0], s3_valid_ff};
      end
   end

   assign dv_valid = dv_chain_ff[DivLat-1] && tag1[TagWidth-1] && tag2;
   assign dv_kind  = tag1[TagWidth-2 -: KindWidth];
   assign dv_neg1  = tag1[1];
   assign dv_neg2  = tag1[0];

   function automatic logic [ValWidth-1:0] sat_val(input logic [QuoWidth-1:0] mag,
                                                   input logic neg);
      logic [QuoWidth:0] lim;
      begin
         lim = neg ? (QuoWidth+1)'(33'h080000000) : (QuoWidth+1)'(33'h07FFFFFFF);
         if ((QuoWidth+1)'(mag) > lim) mag = QuoWidth'(lim);
         sat_val = neg ? ValWidth'(-mag) : ValWidth'(mag);
      end
   endfunction

   logic [ValWidth-1:0] f1_in, f2_in;
   always_comb begin
      f1_in = sat_val(q1, dv_neg1);
      f2_in = sat_val(q2, dv_neg2);
      case (dv_kind) inside
         KIND_LINEAR: f2_in = '0;
         KIND_INFINITE, KIND_NONE: begin
            f1_in = '0;
            f2_in = '0;
         end
         default: ;
      endcase
   end

   logic                 rsp_valid_ff;
   logic [KindWidth-1:0] rsp_kind_ff;
   logic [ValWidth-1:0]  rsp_v1_ff, rsp_v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         rsp_kind_ff <= dv_kind;
         rsp_v1_ff   <= f1_in;
         rsp_v2_ff   <= f2_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_solution_kind = rsp_kind_ff;
   assign rsp_first_value   = rsp_v1_ff;
   assign rsp_second_value  = rsp_v2_ff;

endmodule : quadratic_root_solver_unit
`default_nettype wire
